// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the step sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/ssg_pkg.sv =====
// Package with the types and constants of the swing step sequencer.
package ssg_pkg;

   // Default number of entries in the step table.
   localparam int SSG_STEPS = 16;

   // Input word kinds.
   localparam logic [2:0] KIND_TICK  = 3'd0;
   localparam logic [2:0] KIND_PLAY  = 3'd1;
   localparam logic [2:0] KIND_STOP  = 3'd2;
   localparam logic [2:0] KIND_RESET = 3'd3;
   localparam logic [2:0] KIND_WRITE = 3'd4;

   // Control register indexes.
   localparam logic [2:0] CSR_ENABLED     = 3'd0;
   localparam logic [2:0] CSR_STEP_COUNT  = 3'd1;
   localparam logic [2:0] CSR_STEP_PERIOD = 3'd2;
   localparam logic [2:0] CSR_SWING       = 3'd3;
   localparam logic [2:0] CSR_GLOBAL_GATE = 3'd4;

   // Control register reset values.
   localparam logic        ENABLED_RST     = 1'b1;
   localparam logic [4:0]  STEP_COUNT_RST  = 5'd16;
   localparam logic [31:0] STEP_PERIOD_RST = 32'd1536000;
   localparam logic [7:0]  SWING_RST       = 8'd0;
   localparam logic [8:0]  GLOBAL_GATE_RST = 9'd256;

   // Fixed-point limits.
   localparam logic [31:0] PERIOD_MIN = 32'd256;
   localparam logic [7:0]  SWING_MAX  = 8'd128;
   localparam logic [8:0]  GATE_MIN   = 9'd3;
   localparam logic [8:0]  GATE_ONE   = 9'd256;

   // Datapath widths: Q26.8 phase, step length, multiplier operands.
   localparam int PHASE_W = 34;
   localparam int LEN_W   = 33;
   localparam int MUL_A_W = 42;
   localparam int MUL_B_W = 9;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};
   localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(256);

   // One step table entry.
   typedef struct packed {
      logic       active;
      logic [6:0] note;
      logic [6:0] velocity;
      logic [8:0] gate;
      logic       tie;
   } entry_type;

   // One result word.
   typedef struct packed {
      logic       note_off_valid;
      logic [6:0] note_off_number;
      logic       note_on_valid;
      logic [6:0] note_on_number;
      logic [6:0] note_on_velocity;
      logic       stepped;
      logic [3:0] step_number;
   } result_type;

endpackage

// ===== rtl/ssg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ssg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/step_sequencer_swing_gate.sv =====
// Top level of the sample-rate step sequencer with swing and gate timing.
// Each request word is a sample tick, a play, stop or reset command, or a
// write of one step table entry, and each yields exactly one response word.
// Commands, writes and ticks while stopped or disabled go straight to the
// response stage. A running tick reads the step entry from the table RAM while
// one shared 42x9 multiplier forms the step length, then length times step
// gate, then times the global gate, and a compare stage decides the note
// events. A tick that crosses a step boundary then runs a remainder, one bit
// per cycle over CW = clog2(STEPS+1) bits (5 for 16 steps), that wraps the step
// index at the step count. The response register lets the next word be
// accepted while a response still waits. The step table resets to rests
// through per-entry valid bits.
`include "assert_macros.svh"

module step_sequencer_swing_gate
   import ssg_pkg::*;
#(
   parameter int STEPS = SSG_STEPS
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [3:0]  req_write_index,
   input  logic        req_step_active,
   input  logic [6:0]  req_step_note,
   input  logic [6:0]  req_step_velocity,
   input  logic [8:0]  req_step_gate,
   input  logic        req_step_tie,
   // Response channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_note_off_valid,
   output logic [6:0]  rsp_note_off_number,
   output logic        rsp_note_on_valid,
   output logic [6:0]  rsp_note_on_number,
   output logic [6:0]  rsp_note_on_velocity,
   output logic        rsp_stepped,
   output logic [3:0]  rsp_step_number,
   // Control register port.
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // Widths that follow from the table depth.
   localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int CW = $clog2(STEPS + 1);
   localparam int DW = 2 * CW;
   localparam int KW = (CW > 1) ? $clog2(CW) : 1;

   // Sequencer state codes.
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_READ     = 3'd1;
   localparam logic [2:0] S_MUL_GATE = 3'd2;
   localparam logic [2:0] S_MUL_GLOB = 3'd3;
   localparam logic [2:0] S_DECIDE   = 3'd4;
   localparam logic [2:0] S_WRAP     = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0]         state_ff, state_in;

   // Control registers.
   logic               enabled_ff, enabled_in;
   logic [4:0]         step_count_ff, step_count_in;
   logic [31:0]        step_period_ff, step_period_in;
   logic [7:0]         swing_ff, swing_in;
   logic [8:0]         global_gate_ff, global_gate_in;

   // Sequencer state.
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [IW-1:0]      cur_step_ff, cur_step_in;
   logic               running_ff, running_in;
   logic               sounding_ff, sounding_in;
   logic [6:0]         sounding_note_ff, sounding_note_in;
   logic [STEPS-1:0]   entry_valid_ff, entry_valid_in;

   // Per-tick working registers.
   entry_type          entry_ff, entry_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [PROD_W-1:0]  prod_ff;
   logic [DW-1:0]      rem_ff, rem_in;
   logic [KW-1:0]      bit_ff, bit_in;
   result_type         res_ff, res_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   // Table RAM and datapath signals.
   logic               ram_wr_en;
   logic [IW-1:0]      ram_wr_addr;
   entry_type          ram_wr_data;
   logic [$bits(entry_type)-1:0] ram_rd_data;
   entry_type          entry_rd;
   logic               req_accept;
   logic               write_in_range;
   logic [31:0]        period_eff;
   logic [7:0]         swing_eff;
   logic [8:0]         gate_eff;
   logic [8:0]         swing_factor;
   logic [CW-1:0]      count_eff;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  product;
   logic [LEN_W-1:0]   len_now;
   logic [LEN_W-1:0]   gate_time;
   logic               gate_hit;
   logic               boundary;
   logic [DW-1:0]      wrap_sub;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;

   // Step table write: the gate is saturated to one before it is stored.
   assign write_in_range       = (32'(req_write_index) < STEPS);
   assign ram_wr_en            = req_accept && (req_kind == KIND_WRITE) && write_in_range;
   assign ram_wr_addr          = IW'(req_write_index);
   assign ram_wr_data.active   = req_step_active;
   assign ram_wr_data.note     = req_step_note;
   assign ram_wr_data.velocity = req_step_velocity;
   assign ram_wr_data.gate     = (req_step_gate > GATE_ONE) ? GATE_ONE : req_step_gate;
   assign ram_wr_data.tie      = req_step_tie;

   ssg_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (STEPS),
      .AW    (IW)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (cur_step_ff),
      .rd_data (ram_rd_data)
   );

   // An entry never written reads as an inactive rest.
   assign entry_rd = entry_valid_ff[cur_step_ff] ? entry_type'(ram_rd_data) : '0;

   // Effective register values after clamping.
   assign period_eff   = (step_period_ff < PERIOD_MIN) ? PERIOD_MIN : step_period_ff;
   assign swing_eff    = (swing_ff > SWING_MAX) ? SWING_MAX : swing_ff;
   assign gate_eff     = (global_gate_ff < GATE_MIN) ? GATE_MIN :
                         ((global_gate_ff > GATE_ONE) ? GATE_ONE : global_gate_ff);
   assign swing_factor = cur_step_ff[0] ? (GATE_ONE + 9'(swing_eff))
                                        : (GATE_ONE - 9'(swing_eff));
   assign count_eff    = (step_count_ff == 5'd0) ? CW'(1) :
                         ((32'(step_count_ff) > STEPS) ? CW'(STEPS) : CW'(step_count_ff));

   // Shared multiplier: step length, then times step gate, then times global gate.
   assign len_now = prod_ff[LEN_W+7:8];

   always_comb begin
      case (state_ff)
         S_READ: begin
            mul_a = MUL_A_W'(period_eff);
            mul_b = swing_factor;
         end
         S_MUL_GATE: begin
            mul_a = MUL_A_W'(len_now);
            mul_b = entry_rd.gate;
         end
         S_MUL_GLOB: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = gate_eff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Gate and boundary decisions on the advanced phase.
   assign gate_time = prod_ff[LEN_W+15:16];
   assign gate_hit  = sounding_ff && !entry_ff.tie && (phase_ff >= PHASE_W'(gate_time));
   assign boundary  = (phase_ff >= PHASE_W'(len_ff));

   // One remainder bit per cycle for the step index wrap.
   assign wrap_sub = DW'(count_eff) << bit_ff;

   // Next-state logic.
   always_comb begin
      state_in         = state_ff;
      enabled_in       = enabled_ff;
      step_count_in    = step_count_ff;
      step_period_in   = step_period_ff;
      swing_in         = swing_ff;
      global_gate_in   = global_gate_ff;
      phase_in         = phase_ff;
      cur_step_in      = cur_step_ff;
      running_in       = running_ff;
      sounding_in      = sounding_ff;
      sounding_note_in = sounding_note_ff;
      entry_valid_in   = entry_valid_ff;
      entry_in         = entry_ff;
      len_in           = len_ff;
      rem_in           = rem_ff;
      bit_in           = bit_ff;
      res_in           = res_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_in           = rsp_ff;

      // Control register writes.
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLED:     enabled_in     = csr_data[0];
            CSR_STEP_COUNT:  step_count_in  = csr_data[4:0];
            CSR_STEP_PERIOD: step_period_in = csr_data;
            CSR_SWING:       swing_in       = csr_data[7:0];
            CSR_GLOBAL_GATE: global_gate_in = csr_data[8:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_in   = '0;
               state_in = S_DONE;
               case (req_kind)
                  KIND_TICK: begin
                     if (enabled_ff && running_ff) begin
                        phase_in = (phase_ff > (PHASE_MAX - PHASE_ONE)) ? PHASE_MAX
                                                                       : phase_ff + PHASE_ONE;
                        state_in = S_READ;
                     end
                  end
                  KIND_PLAY: begin
                     running_in       = 1'b1;
                     phase_in         = PHASE_W'(period_eff);
                     cur_step_in      = '0;
                     sounding_in      = 1'b0;
                     sounding_note_in = '0;
                  end
                  KIND_STOP: begin
                     running_in       = 1'b0;
                     phase_in         = '0;
                     cur_step_in      = '0;
                     sounding_in      = 1'b0;
                     sounding_note_in = '0;
                  end
                  KIND_RESET: begin
                     phase_in    = '0;
                     cur_step_in = '0;
                  end
                  KIND_WRITE: begin
                     if (write_in_range) begin
                        entry_valid_in[ram_wr_addr] = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            state_in = S_MUL_GATE;
         end
         S_MUL_GATE: begin
            entry_in = entry_rd;
            len_in   = len_now;
            state_in = S_MUL_GLOB;
         end
         S_MUL_GLOB: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            // A sounding note is released at the gate time, unless the step is tied, or at the boundary.
            if (sounding_ff && (gate_hit || boundary)) begin
               res_in.note_off_valid  = 1'b1;
               res_in.note_off_number = sounding_note_ff;
            end
            if (boundary) begin
               phase_in           = phase_ff - PHASE_W'(len_ff);
               res_in.stepped     = 1'b1;
               res_in.step_number = 4'(cur_step_ff);
               sounding_in        = entry_ff.active;
               if (entry_ff.active) begin
                  sounding_note_in        = entry_ff.note;
                  res_in.note_on_valid    = 1'b1;
                  res_in.note_on_number   = entry_ff.note;
                  res_in.note_on_velocity = entry_ff.velocity;
               end
               rem_in   = DW'(cur_step_ff) + DW'(1);
               bit_in   = KW'(CW - 1);
               state_in = S_WRAP;
            end else begin
               sounding_in = sounding_ff && !gate_hit;
               state_in    = S_DONE;
            end
         end
         S_WRAP: begin
            // Restoring remainder of the next index by the step count.
            if (rem_ff >= wrap_sub) begin
               rem_in = rem_ff - wrap_sub;
            end
            if (bit_ff == '0) begin
               cur_step_in = rem_in[IW-1:0];
               state_in    = S_DONE;
            end else begin
               bit_in = bit_ff - KW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers and sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         enabled_ff       <= ENABLED_RST;
         step_count_ff    <= STEP_COUNT_RST;
         step_period_ff   <= STEP_PERIOD_RST;
         swing_ff         <= SWING_RST;
         global_gate_ff   <= GLOBAL_GATE_RST;
         phase_ff         <= '0;
         cur_step_ff      <= '0;
         running_ff       <= 1'b0;
         sounding_ff      <= 1'b0;
         sounding_note_ff <= '0;
         entry_valid_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         enabled_ff       <= enabled_in;
         step_count_ff    <= step_count_in;
         step_period_ff   <= step_period_in;
         swing_ff         <= swing_in;
         global_gate_ff   <= global_gate_in;
         phase_ff         <= phase_in;
         cur_step_ff      <= cur_step_in;
         running_ff       <= running_in;
         sounding_ff      <= sounding_in;
         sounding_note_ff <= sounding_note_in;
         entry_valid_ff   <= entry_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      len_ff   <= len_in;
      prod_ff  <= product;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // Response ports.
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_note_off_valid   = rsp_ff.note_off_valid;
   assign rsp_note_off_number  = rsp_ff.note_off_number;
   assign rsp_note_on_valid    = rsp_ff.note_on_valid;
   assign rsp_note_on_number   = rsp_ff.note_on_number;
   assign rsp_note_on_velocity = rsp_ff.note_on_velocity;
   assign rsp_stepped          = rsp_ff.stepped;
   assign rsp_step_number      = rsp_ff.step_number;

   // The step index always stays inside the table.
   `ASSERT_IMPLIES(step_in_table_a, clock, reset, 1'b1, 32'(cur_step_ff) < STEPS)
   // A note-on is only ever issued on a step boundary.
   `ASSERT_IMPLIES(note_on_stepped_a, clock, reset, rsp_valid && rsp_note_on_valid, rsp_stepped)
   // Commands and writes go straight to the response stage.
   `ASSERT_NEXT(cmd_done_a, clock, reset, req_accept && (req_kind != KIND_TICK), state_ff == S_DONE)

endmodule

// ===== verif/sequencer_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts every response word of the swing step sequencer and compares it.
module sequencer_checker
   import ssg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [3:0]  req_write_index,
   input  logic        req_step_active,
   input  logic [6:0]  req_step_note,
   input  logic [6:0]  req_step_velocity,
   input  logic [8:0]  req_step_gate,
   input  logic        req_step_tie,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_note_off_valid,
   input  logic [6:0]  rsp_note_off_number,
   input  logic        rsp_note_on_valid,
   input  logic [6:0]  rsp_note_on_number,
   input  logic [6:0]  rsp_note_on_velocity,
   input  logic        rsp_stepped,
   input  logic [3:0]  rsp_step_number,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          mismatches,
   output int          pending,
   output int          boundaries,
   output int          notes_started,
   output int          notes_released
);

   // One sample in Q26.8, also unity for the Q0.8 swing term.
   localparam longint unsigned UNIT_Q8 = 256;

   // Sequencer state as the block should hold it.
   entry_type          step_entries [SSG_STEPS];
   logic [PHASE_W-1:0] seq_phase;
   logic [3:0]         seq_step;
   logic               seq_running;
   logic               note_held;
   logic [6:0]         held_note;

   // Register copies, updated from the write port.
   logic        cfg_enabled;
   logic [4:0]  cfg_count;
   logic [31:0] cfg_period;
   logic [7:0]  cfg_swing;
   logic [8:0]  cfg_gate;

   // Response words still owed by the block, oldest first.
   result_type owed_words [$];
   result_type want;

   // Return state and registers to their values after reset.
   function automatic void clear_sequencer();
      for (int i = 0; i < SSG_STEPS; i++) begin
         step_entries[i] = '0;
      end
      seq_phase   = '0;
      seq_step    = '0;
      seq_running = 1'b0;
      note_held   = 1'b0;
      held_note   = '0;
      cfg_enabled = ENABLED_RST;
      cfg_count   = STEP_COUNT_RST;
      cfg_period  = STEP_PERIOD_RST;
      cfg_swing   = SWING_RST;
      cfg_gate    = GLOBAL_GATE_RST;
   endfunction

   // Apply one request word to the state and return the response it must produce.
   function automatic result_type sequence_word(input logic [2:0] kind,
                                                input logic [3:0] index,
                                                input entry_type written);
      result_type             r;
      entry_type              here;
      longint unsigned        period, swing, scale, step_len, gate_len;
      int                     loop_len;
      r      = '0;
      period = (cfg_period < PERIOD_MIN) ? longint'(PERIOD_MIN) : longint'(cfg_period);
      case (kind)
         KIND_PLAY: begin
            seq_running = 1'b1;
            seq_phase   = period[PHASE_W-1:0];
            seq_step    = '0;
            note_held   = 1'b0;
            held_note   = '0;
         end
         KIND_STOP: begin
            seq_running = 1'b0;
            seq_phase   = '0;
            seq_step    = '0;
            note_held   = 1'b0;
            held_note   = '0;
         end
         KIND_RESET: begin
            seq_phase = '0;
            seq_step  = '0;
         end
         KIND_WRITE: begin
            // A gate above one is clipped to one.
            if (int'(index) < SSG_STEPS) begin
               here = written;
               if (here.gate > GATE_ONE) begin
                  here.gate = GATE_ONE;
               end
               step_entries[index] = here;
            end
         end
         KIND_TICK: begin
            if (cfg_enabled && seq_running) begin
               here  = step_entries[seq_step];
               swing = (cfg_swing > SWING_MAX) ? longint'(SWING_MAX) : longint'(cfg_swing);
               if (cfg_gate < GATE_MIN) begin
                  scale = longint'(GATE_MIN);
               end else if (cfg_gate > GATE_ONE) begin
                  scale = longint'(GATE_ONE);
               end else begin
                  scale = longint'(cfg_gate);
               end
               loop_len = (cfg_count == 0) ? 1 :
                          (int'(cfg_count) > SSG_STEPS) ? SSG_STEPS : int'(cfg_count);

               // Advance one sample, holding at the top of the phase range.
               if (seq_phase > PHASE_MAX - PHASE_ONE) begin
                  seq_phase = PHASE_MAX;
               end else begin
                  seq_phase = seq_phase + PHASE_ONE;
               end

               // Odd steps are stretched by swing and even steps shortened.
               if (seq_step[0]) begin
                  step_len = (period * (UNIT_Q8 + swing)) >> 8;
               end else begin
                  step_len = (period * (UNIT_Q8 - swing)) >> 8;
               end
               gate_len = (step_len * longint'(here.gate) * scale) >> 16;

               // Gate end releases the note unless the step is tied.
               if (note_held && !here.tie && longint'(seq_phase) >= gate_len) begin
                  r.note_off_valid  = 1'b1;
                  r.note_off_number = held_note;
                  note_held         = 1'b0;
               end

               // Step boundary: release, fire the step, move to the next one.
               if (longint'(seq_phase) >= step_len) begin
                  seq_phase = seq_phase - step_len[PHASE_W-1:0];
                  if (note_held) begin
                     r.note_off_valid  = 1'b1;
                     r.note_off_number = held_note;
                     note_held         = 1'b0;
                  end
                  r.stepped     = 1'b1;
                  r.step_number = seq_step;
                  if (here.active) begin
                     held_note          = here.note;
                     note_held          = 1'b1;
                     r.note_on_valid    = 1'b1;
                     r.note_on_number   = here.note;
                     r.note_on_velocity = here.velocity;
                  end
                  seq_step = 4'((int'(seq_step) + 1) % loop_len);
               end
            end
         end
         default: begin
            // Spare kinds leave the state alone.
         end
      endcase
      return r;
   endfunction

   // Report one field that differs from its prediction.
   task automatic compare_field(input string field, input int expected_value,
                                input int actual_value);
      if (expected_value != actual_value) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d",
                  $time, field, expected_value, actual_value);
         mismatches = mismatches + 1;
      end
   endtask

   // Track register writes, predict each accepted request word and check responses.
   always @(posedge clock) begin
      if (reset) begin
         clear_sequencer();
         owed_words.delete();
         mismatches     = 0;
         boundaries     = 0;
         notes_started  = 0;
         notes_released = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ENABLED:     cfg_enabled = csr_data[0];
               CSR_STEP_COUNT:  cfg_count   = csr_data[4:0];
               CSR_STEP_PERIOD: cfg_period  = csr_data;
               CSR_SWING:       cfg_swing   = csr_data[7:0];
               CSR_GLOBAL_GATE: cfg_gate    = csr_data[8:0];
               default: begin
               end
            endcase
         end

         if (req_valid && req_ready) begin
            owed_words.push_back(sequence_word(req_kind, req_write_index,
               '{req_step_active, req_step_note, req_step_velocity,
                 req_step_gate, req_step_tie}));
         end

         if (rsp_valid && rsp_ready) begin
            if (owed_words.size() == 0) begin
               $display("%0t: response word with nothing expected: expected none, actual %h",
                        $time, {rsp_note_off_valid, rsp_note_off_number, rsp_note_on_valid,
                                rsp_note_on_number, rsp_note_on_velocity, rsp_stepped,
                                rsp_step_number});
               mismatches = mismatches + 1;
            end else begin
               want = owed_words.pop_front();
               compare_field("note_off_valid", want.note_off_valid, rsp_note_off_valid);
               compare_field("note_off_number", want.note_off_number, rsp_note_off_number);
               compare_field("note_on_valid", want.note_on_valid, rsp_note_on_valid);
               compare_field("note_on_number", want.note_on_number, rsp_note_on_number);
               compare_field("note_on_velocity", want.note_on_velocity,
                             rsp_note_on_velocity);
               compare_field("stepped", want.stepped, rsp_stepped);
               compare_field("step_number", want.step_number, rsp_step_number);
               boundaries     = boundaries + int'(want.stepped);
               notes_started  = notes_started + int'(want.note_on_valid);
               notes_released = notes_released + int'(want.note_off_valid);
            end
         end
      end
      pending = owed_words.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// Top of the swing step sequencer test: clock, reset, stimulus and the verdict.
module testbench
   import ssg_pkg::*;
();

   localparam int CYCLE_LIMIT     = 800000;
   localparam int SETTLE_CYCLES   = 16;
   localparam int PHASES          = 16;
   localparam int WORDS_PER_PHASE = 96;

   // Request kinds that the block ignores.
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

   // Ways the response side holds off.
   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_BLOCKED} ready_mode_type;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [2:0]  req_kind          = KIND_TICK;
   logic [3:0]  req_write_index   = '0;
   logic        req_step_active   = 1'b0;
   logic [6:0]  req_step_note     = '0;
   logic [6:0]  req_step_velocity = '0;
   logic [8:0]  req_step_gate     = '0;
   logic        req_step_tie      = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic        rsp_note_off_valid;
   logic [6:0]  rsp_note_off_number;
   logic        rsp_note_on_valid;
   logic [6:0]  rsp_note_on_number;
   logic [6:0]  rsp_note_on_velocity;
   logic        rsp_stepped;
   logic [3:0]  rsp_step_number;
   logic        csr_write_enable  = 1'b0;
   logic [2:0]  csr_index         = CSR_ENABLED;
   logic [31:0] csr_data          = '0;

   int mismatches;
   int pending;
   int boundaries;
   int notes_started;
   int notes_released;
   int words_sent  = 0;
   int cycle_count = 0;

   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 0;
   int             block_left = 0;
   logic           ready_next;

   step_sequencer_swing_gate dut (.*);

   sequencer_checker checker_0 (.*);

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Give up if the run takes far longer than any correct one could.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("step_sequencer_swing_gate test failed");
         $finish;
      end
   end

   // Response-side stalls: the pattern switches between randomly chosen modes.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(50, 400);
      end
      mode_left = mode_left - 1;
      case (ready_mode)
         READY_ALWAYS: ready_next = 1'b1;
         READY_COIN:   ready_next = 1'($urandom_range(0, 1));
         READY_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
         default: begin
            if (block_left > 0) begin
               block_left = block_left - 1;
               ready_next = 1'b0;
            end else begin
               ready_next = 1'b1;
               if ($urandom_range(0, 7) == 0) begin
                  block_left = $urandom_range(10, 30);
               end
            end
         end
      endcase
      rsp_ready <= ready_next;
   end

   // Present one request word and hold it until accepted; returns on a falling edge.
   task automatic send_word(input logic [2:0] kind, input logic [3:0] index,
                            input logic active, input logic [6:0] note,
                            input logic [6:0] velocity, input logic [8:0] gate,
                            input logic tie);
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_write_index   <= index;
      req_step_active   <= active;
      req_step_note     <= note;
      req_step_velocity <= velocity;
      req_step_gate     <= gate;
      req_step_tie      <= tie;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent = words_sent + 1;
   endtask

   // Send a word of the given kind with random content; gates lean toward the legal range.
   task automatic send_random(input logic [2:0] kind);
      logic [8:0] gate;
      gate = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(257, 511))
                                         : 9'($urandom_range(0, 256));
      send_word(kind, 4'($urandom_range(0, 15)), $urandom_range(0, 9) < 7,
                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), gate,
                $urandom_range(0, 3) == 0);
   endtask

   task automatic pause(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Hold off until every expected response word has arrived and the block is quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Drive one register write; the caller lowers the write enable.
   task automatic put_reg(input logic [2:0] index, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= data;
      @(negedge clock);
   endtask

   task automatic write_settings(input logic enabled, input logic [4:0] count,
                                 input logic [31:0] period, input logic [7:0] swing,
                                 input logic [8:0] gate);
      put_reg(CSR_ENABLED, 32'(enabled));
      put_reg(CSR_STEP_COUNT, 32'(count));
      put_reg(CSR_STEP_PERIOD, period);
      put_reg(CSR_SWING, 32'(swing));
      put_reg(CSR_GLOBAL_GATE, 32'(gate));
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly ticks over a running loop, with table writes, transport commands and spare kinds.
   task automatic run_phase(input int count, input bit steady);
      int         done;
      int         burst_left;
      int         pick;
      logic [2:0] kind;
      done       = 0;
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 1) == 1) begin
         send_random(KIND_PLAY);
         done = done + 1;
      end
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            kind = KIND_TICK;
         end else if (pick < 84) begin
            kind = KIND_WRITE;
         end else if (pick < 88) begin
            kind = KIND_PLAY;
         end else if (pick < 90) begin
            kind = KIND_STOP;
         end else if (pick < 93) begin
            kind = KIND_RESET;
         end else begin
            kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
         end
         send_random(kind);
         if (kind <= KIND_WRITE) begin
            done = done + 1;
         end
         if (!steady) begin
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
               if ($urandom_range(0, 3) != 0) begin
                  pause($urandom_range(1, 8));
               end
               burst_left = $urandom_range(1, 24);
            end
         end
         // Now and then let the pipeline empty completely before going on.
         if ($urandom_range(0, 199) == 0) begin
            drain();
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under reset settings: idle tick, table extremes, spare kinds, commands.
      send_word(KIND_TICK, 4'd0, 1'b0, 7'd0, 7'd0, 9'd0, 1'b0);
      send_word(KIND_WRITE, 4'd0, 1'b1, 7'd127, 7'd127, 9'd511, 1'b0);
      send_word(KIND_WRITE, 4'd15, 1'b1, 7'd0, 7'd0, 9'd0, 1'b1);
      send_word(KIND_WRITE, 4'd1, 1'b1, 7'd60, 7'd100, 9'd128, 1'b0);
      send_word(KIND_WRITE, 4'd2, 1'b0, 7'd64, 7'd90, 9'd256, 1'b0);
      send_word(KIND_WRITE, 4'd3, 1'b1, 7'd67, 7'd1, 9'd64, 1'b1);
      for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
         send_word(3'(k), 4'd0, 1'b1, 7'd127, 7'd127, 9'd511, 1'b1);
      end
      send_word(KIND_PLAY, 4'd0, 1'b0, 7'd0, 7'd0, 9'd0, 1'b0);
      send_word(KIND_TICK, 4'd0, 1'b0, 7'd0, 7'd0, 9'd0, 1'b0);
      send_word(KIND_TICK, 4'd0, 1'b0, 7'd0, 7'd0, 9'd0, 1'b0);
      send_word(KIND_RESET, 4'd0, 1'b0, 7'd0, 7'd0, 9'd0, 1'b0);
      send_word(KIND_TICK, 4'd0, 1'b0, 7'd0, 7'd0, 9'd0, 1'b0);
      send_word(KIND_STOP, 4'd0, 1'b0, 7'd0, 7'd0, 9'd0, 1'b0);
      send_word(KIND_TICK, 4'd0, 1'b0, 7'd0, 7'd0, 9'd0, 1'b0);
      drain();

      // A short four-step loop where gates end inside the step.
      write_settings(1'b1, 5'd4, 32'd1024, 8'd0, 9'd128);
      send_word(KIND_PLAY, 4'd0, 1'b0, 7'd0, 7'd0, 9'd0, 1'b0);
      repeat (8) send_word(KIND_TICK, 4'd0, 1'b0, 7'd0, 7'd0, 9'd0, 1'b0);
      drain();

      // Random part over a series of register settings, extremes first.
      for (int phase_no = 0; phase_no < PHASES; phase_no++) begin
         case (phase_no)
            0: write_settings(1'b1, 5'd16, 32'd256, 8'd0, GATE_ONE);
            1: write_settings(1'b1, 5'd16, 32'd2048, SWING_MAX, GATE_MIN);
            2: write_settings(1'b1, 5'd5, 32'd1000, 8'd64, 9'd200);
            3: write_settings(1'b0, 5'd16, 32'd512, 8'd0, GATE_ONE);
            4: write_settings(1'b1, 5'd0, 32'd0, 8'd255, 9'd0);
            5: write_settings(1'b1, 5'd31, 32'd255, 8'd200, 9'd511);
            6: write_settings(1'b1, 5'd16, 32'hFFFF_FFFF, SWING_MAX, GATE_ONE);
            default: begin
               write_settings($urandom_range(0, 7) != 0, 5'($urandom_range(0, 31)),
                              ($urandom_range(0, 3) == 0) ? $urandom
                                                          : $urandom_range(0, 3072),
                              8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
            end
         endcase
         run_phase(WORDS_PER_PHASE, phase_no % 4 == 3);
         drain();
      end

      $display("Summary: %0d request words over %0d register settings.", words_sent,
               PHASES + 2);
      $display("Summary: %0d step boundaries, %0d note-ons and %0d note-offs checked.",
               boundaries, notes_started, notes_released);
      if (mismatches == 0 && pending == 0) begin
         $display("step_sequencer_swing_gate test passed");
      end else begin
         $display("step_sequencer_swing_gate test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ssg_pkg.sv
rtl/ssg_ram.sv
rtl/step_sequencer_swing_gate.sv
verif/sequencer_checker.sv
verif/testbench.sv
